// ===== src/dtwc_pkg.sv =====
package dtwc_pkg;

  localparam int unsigned TimeW     = 64;
  localparam int unsigned WinW      = 32;
  localparam int unsigned WinFracW  = 16;
  localparam int unsigned PktW      = 16;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned FactorW   = 16;
  localparam int unsigned NumW      = 8;
  localparam int unsigned CountW    = 8;
  localparam int unsigned ActionW   = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ProdW     = WinW + FactorW;

  // The increase term is (numerator << 32) / window, so the dividend has
  // NumW + WinW bits and the quotient may be as wide as the dividend.
  localparam int unsigned DivDendW  = NumW + WinW;
  localparam int unsigned DivSorW   = WinW;
  localparam int unsigned DivSteps  = DivDendW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [WinW-1:0]     WindowReset    = 32'h0001_0000;
  localparam logic [ThrW-1:0]     ThresholdReset = 16'd75;
  localparam logic [FactorW-1:0]  FactorReset    = 16'd39322;
  localparam logic [NumW-1:0]     NumeratorReset = 8'd10;
  localparam logic [CountW-1:0]   TargetReset    = 8'd4;

  localparam logic [ActionW-1:0] ActNone      = 2'd0;
  localparam logic [ActionW-1:0] ActDecreased = 2'd1;
  localparam logic [ActionW-1:0] ActIncreased = 2'd2;
  localparam logic [ActionW-1:0] ActCounted   = 2'd3;

  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFactor    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNumerator = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTarget    = 2'd3;

  typedef struct packed {
    logic                start;
    logic [DivDendW-1:0] dividend;
    logic [DivSorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivDendW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/dtwc_div.sv =====
module dtwc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dtwc_pkg::div_req_t req,
  output dtwc_pkg::div_rsp_t rsp
);
  import dtwc_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [DivCntW-1:0]  cnt_r;
  logic [DivSorW-1:0]  sor_r;
  logic [DivSorW-1:0]  rem_r;
  logic [DivDendW-1:0] quo_r;

  logic [DivSorW:0]    trial;
  logic                fits;
  logic [DivSorW:0]    diff;

  // One restoring step per cycle: the dividend shifts out of the top of
  // quo_r while quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem_r, quo_r[DivDendW-1]};
    fits  = (trial >= {1'b0, sor_r});
    diff  = trial - {1'b0, sor_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DivCntW'(DivSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sor_r <= req.divisor;
      rem_r <= '0;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DivSorW-1:0] : trial[DivSorW-1:0];
      quo_r <= {quo_r[DivDendW-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== src/delay_triggered_window_control.sv =====
// Delay-triggered window control: one acknowledgement in, one result out.
//
// Each transfer on the input channel (in_valid high, in_stall low) carries
// the send and arrival timestamps of one acknowledgement. The block answers
// every acknowledgement with exactly one transfer on the output channel,
// giving the integer part of the congestion window and the action taken.
// Only one acknowledgement is worked on at a time; in_stall stays high from
// the transfer until the result has been loaded into the output register.
//
// A count-only or no-change acknowledgement passes through the evaluation
// and output steps; a decrease adds a step that applies the product, and an
// increase waits in the divide step for the single restoring divider, which
// retires one of its 40 quotient bits per cycle. The next acknowledgement
// can be taken as soon as the result is loaded into the output register.
//
// A held result does not block input: the block finishes its work and only
// waits in its final step while the output register is still full. Under
// out_stall, out_valid and the payload hold unchanged. Synchronous reset
// restores the configuration defaults, sets the window to 1.0, disarms the
// decrease and clears the count.
module delay_triggered_window_control (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dtwc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dtwc_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dtwc_pkg::TimeW-1:0]    in_sent_time,
  input  logic [dtwc_pkg::TimeW-1:0]    in_ack_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dtwc_pkg::PktW-1:0]     out_window_packets,
  output logic [dtwc_pkg::ActionW-1:0]  out_action_taken
);
  import dtwc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DEC,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [ThrW-1:0]    thr_r;
  logic [FactorW-1:0] factor_r;
  logic [NumW-1:0]    num_r;
  logic [CountW-1:0]  target_r;

  // Algorithm state.
  logic [WinW-1:0]    window_r;
  logic               armed_r;
  logic [CountW-1:0]  count_r;

  // Working registers.
  logic [TimeW-1:0]   delay_r;
  logic [ProdW-1:0]   prod_r;
  logic [ActionW-1:0] action_r;
  div_req_t           div_req_r;
  div_rsp_t           div_rsp;

  logic               out_valid_r;
  logic [PktW-1:0]    out_pkts_r;
  logic [ActionW-1:0] out_action_r;

  // Delay comparison against the zero-extended threshold.
  logic               delay_hi;
  logic               delay_gt;
  logic               delay_lt;
  logic [WinW:0]      grown;
  logic               out_free;

  always_comb begin
    delay_hi = |delay_r[TimeW-1:ThrW];
    delay_gt = delay_hi || (delay_r[ThrW-1:0] > thr_r);
    delay_lt = !delay_hi && (delay_r[ThrW-1:0] < thr_r);
    grown    = {1'b0, window_r} + {1'b0, div_rsp.quotient[WinW-1:0]};
    out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= ThresholdReset;
      factor_r <= FactorReset;
      num_r    <= NumeratorReset;
      target_r <= TargetReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegThreshold: thr_r    <= cfg_wdata[ThrW-1:0];
        RegFactor:    factor_r <= cfg_wdata[FactorW-1:0];
        RegNumerator: num_r    <= cfg_wdata[NumW-1:0];
        RegTarget:    target_r <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer: one clocked block for the state, the algorithm state and
  // the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      window_r        <= WindowReset;
      armed_r         <= 1'b0;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      // The divider is started on the way out of the evaluation step.
      div_req_r.start <= (state_r == S_EVAL) && delay_lt && (count_r == target_r);
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            delay_r <= in_ack_time - in_sent_time;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (delay_gt && armed_r) begin
            prod_r  <= window_r * factor_r;
            state_r <= S_DEC;
          end else if (delay_lt && (count_r == target_r)) begin
            div_req_r.dividend <= {num_r, {WinW{1'b0}}};
            // A zero window is divided as one least significant bit.
            div_req_r.divisor  <= (window_r == '0) ? WinW'(1) : window_r;
            state_r            <= S_DIV;
          end else if (delay_lt) begin
            count_r  <= count_r + 1'b1;
            action_r <= ActCounted;
            state_r  <= S_OUT;
          end else begin
            action_r <= ActNone;
            state_r  <= S_OUT;
          end
        end
        S_DEC: begin
          window_r <= prod_r[ProdW-1:WinFracW];
          armed_r  <= 1'b0;
          action_r <= ActDecreased;
          state_r  <= S_OUT;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            // Saturate when the quotient or the sum leaves 32 bits.
            if (grown[WinW] || (|div_rsp.quotient[DivDendW-1:WinW])) begin
              window_r <= '1;
            end else begin
              window_r <= grown[WinW-1:0];
            end
            armed_r  <= 1'b1;
            count_r  <= '0;
            action_r <= ActIncreased;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_pkts_r   <= window_r[WinW-1:WinFracW];
            out_action_r <= action_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  dtwc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_window_packets = out_pkts_r;
  assign out_action_taken   = out_action_r;

endmodule
